### rtl/core/sbc_pkg.sv
package sbc_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int NORM_WIDTH      = 16;
   localparam int NORM_ONE        = 16384;
   localparam int NORM_SHIFT      = 14;

   // register indexes of the box corners
   typedef enum logic [2:0] {
      REG_MIN_X = 3'd0,
      REG_MIN_Y = 3'd1,
      REG_MIN_Z = 3'd2,
      REG_MAX_X = 3'd3,
      REG_MAX_Y = 3'd4,
      REG_MAX_Z = 3'd5
   } reg_index_type;

endpackage

### rtl/core/sbc_if.sv
interface sbc_req_if #(parameter int CW = 16) ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] center_x;
   logic signed [CW-1:0] center_y;
   logic signed [CW-1:0] center_z;
   logic [CW-2:0]        radius;
   modport source (output valid, center_x, center_y, center_z, radius, input ready);
   modport sink   (input valid, center_x, center_y, center_z, radius, output ready);
endinterface

interface sbc_rsp_if #(parameter int CW = 16) ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic signed [CW-1:0] contact_x;
   logic signed [CW-1:0] contact_y;
   logic signed [CW-1:0] contact_z;
   logic signed [15:0]   normal_x;
   logic signed [15:0]   normal_y;
   logic signed [15:0]   normal_z;
   logic [CW-2:0]        depth;
   modport source (output valid, hit, contact_x, contact_y, contact_z,
                   normal_x, normal_y, normal_z, depth, input ready);
   modport sink   (input valid, hit, contact_x, contact_y, contact_z,
                   normal_x, normal_y, normal_z, depth, output ready);
endinterface

### rtl/core/sphere_box_collision.sv
// Channel   | Dir | Payload
// req       | in  | center_x/y/z, radius
// rsp       | out | hit, contact_x/y/z, normal_x/y/z, depth
// csr       | in  | APB write/read of box corners
// One request enters per cycle while the output is not stalled; the chain holds
// one clamp cell, one square cell, one radius-compare cell, CW+1 root cells,
// one rounding cell, CW+15 divide cells and one output cell.
// Synchronous active-high reset clears all valid flags.
// The whole chain stalls when the output holds a result that is not taken.
module sphere_box_collision
   import sbc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sbc_req_if.sink     req,
   sbc_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int CW = COORD_WIDTH;
   localparam int DW = 2*CW+2;
   localparam int RW = CW+1;
   logic signed [CW-1:0] lo_ff [3];
   logic signed [CW-1:0] hi_ff [3];
   logic [2:0] idx;

   // configuration registers
   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= '0;
            hi_ff[i] <= '0;
         end
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (idx)
            REG_MIN_X: lo_ff[0] <= csr_pwdata[CW-1:0];
            REG_MIN_Y: lo_ff[1] <= csr_pwdata[CW-1:0];
            REG_MIN_Z: lo_ff[2] <= csr_pwdata[CW-1:0];
            REG_MAX_X: hi_ff[0] <= csr_pwdata[CW-1:0];
            REG_MAX_Y: hi_ff[1] <= csr_pwdata[CW-1:0];
            REG_MAX_Z: hi_ff[2] <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (idx)
         REG_MIN_X: csr_prdata = 32'(lo_ff[0]);
         REG_MIN_Y: csr_prdata = 32'(lo_ff[1]);
         REG_MIN_Z: csr_prdata = 32'(lo_ff[2]);
         REG_MAX_X: csr_prdata = 32'(hi_ff[0]);
         REG_MAX_Y: csr_prdata = 32'(hi_ff[1]);
         REG_MAX_Z: csr_prdata = 32'(hi_ff[2]);
         default:   csr_prdata = '0;
      endcase
   end

   // chain enable: advance unless a result is stuck at the output
   logic en;
   assign en = !rsp.valid || rsp.ready;
   assign req.ready = en;

   // stage 1: clamp and early tests
   logic s1_v_ff, s1_inbox_ff, s1_miss_ff;
   logic [2:0] s1_neg_ff;
   logic signed [CW-1:0] s1_p_ff [3];
   logic [CW-1:0] s1_ad_ff [3];
   logic [CW-2:0] s1_r_ff;
   logic signed [CW-1:0] c [3];
   logic signed [CW:0] df [3];
   logic [CW:0] adf [3];
   logic signed [CW-1:0] pc [3];
   logic ins, ms;
   always_comb begin
      c[0] = req.center_x; c[1] = req.center_y; c[2] = req.center_z;
      ins = 1'b1; ms = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (c[i] < lo_ff[i] || c[i] > hi_ff[i]) ins = 1'b0;
         if (lo_ff[i] > c[i]) pc[i] = lo_ff[i];
         else if (hi_ff[i] < c[i]) pc[i] = hi_ff[i];
         else pc[i] = c[i];
         df[i] = (CW+1)'(c[i]) - (CW+1)'(pc[i]);
         adf[i] = df[i][CW] ? (CW+1)'(-df[i]) : (CW+1)'(df[i]);
         if (adf[i] > (CW+1)'(req.radius)) ms = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= req.valid;
      if (en) begin
         s1_inbox_ff <= ins;
         s1_miss_ff   <= ms;
         s1_r_ff      <= req.radius;
         for (int i = 0; i < 3; i++) begin
            s1_p_ff[i]  <= pc[i];
            s1_neg_ff[i] <= df[i][CW];
            s1_ad_ff[i] <= adf[i][CW-1:0];
         end
      end
   end

   // stage 2: squares (early miss bounds |d| to radius, so CW bits hold)
   logic s2_v_ff, s2_inbox_ff, s2_miss_ff;
   logic [2:0] s2_neg_ff;
   logic signed [CW-1:0] s2_p_ff [3];
   logic [CW-1:0] s2_ad_ff [3];
   logic [CW-2:0] s2_r_ff;
   logic [DW-1:0] s2_dsq_ff;
   logic [2*CW-1:0] s2_rsq_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (en) s2_v_ff <= s1_v_ff;
      if (en) begin
         s2_inbox_ff <= s1_inbox_ff;
         s2_neg_ff    <= s1_neg_ff;
         s2_p_ff      <= s1_p_ff;
         s2_ad_ff     <= s1_ad_ff;
         s2_r_ff      <= s1_r_ff;
         s2_dsq_ff    <= DW'(s1_ad_ff[0]*s1_ad_ff[0]) + DW'(s1_ad_ff[1]*s1_ad_ff[1])
                         + DW'(s1_ad_ff[2]*s1_ad_ff[2]);
         s2_rsq_ff    <= (2*CW)'(s1_r_ff) * (2*CW)'(s1_r_ff);
         s2_miss_ff   <= s1_miss_ff;
      end
   end

   // root chain: one cell per root bit, restoring method
   typedef struct packed {
      logic            inbox;
      logic            miss;
      logic [2:0]      neg;
      logic [3*CW-1:0] p;
      logic [3*CW-1:0] ad;
      logic [CW-2:0]   r;
      logic [DW-1:0]   rem;
      logic [RW-1:0]   root;
   } rt_type;
   rt_type rt_ff [RW+1];
   logic   rt_v_ff [RW+1];
   always_ff @(posedge clock) begin
      if (reset) rt_v_ff[0] <= 1'b0;
      else if (en) rt_v_ff[0] <= s2_v_ff;
      if (en) begin
         rt_ff[0].inbox  <= s2_inbox_ff;
         rt_ff[0].miss   <= s2_miss_ff || (DW'(s2_dsq_ff) > DW'(s2_rsq_ff));
         rt_ff[0].neg    <= s2_neg_ff;
         rt_ff[0].p      <= {s2_p_ff[2], s2_p_ff[1], s2_p_ff[0]};
         rt_ff[0].ad     <= {s2_ad_ff[2], s2_ad_ff[1], s2_ad_ff[0]};
         rt_ff[0].r      <= s2_r_ff;
         rt_ff[0].rem    <= s2_dsq_ff;
         rt_ff[0].root   <= '0;
      end
   end
   for (genvar k = 0; k < RW; k++) begin : g_root
      localparam int B = RW-1-k;
      logic [DW+1:0] trial;
      rt_type nx;
      always_comb begin
         nx = rt_ff[k];
         trial = {2'b0, rt_ff[k].rem}
                 - (({{(DW+2-RW){1'b0}}, rt_ff[k].root} << (B+1))
                    | ({{(DW+1){1'b0}}, 1'b1} << (2*B)));
         if (!trial[DW+1]) begin
            nx.rem  = trial[DW-1:0];
            nx.root = rt_ff[k].root | (RW'(1) << B);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) rt_v_ff[k+1] <= 1'b0;
         else if (en) rt_v_ff[k+1] <= rt_v_ff[k];
         if (en) rt_ff[k+1] <= nx;
      end
   end

   // rounding cell: dist = root+1 when remainder exceeds root, and never below 1
   localparam int QW = CW + NORM_SHIFT + 1;   // dividend width |d|<<14 + half
   typedef struct packed {
      logic            inbox;
      logic            miss;
      logic [2:0]      neg;
      logic [3*CW-1:0] p;
      logic [CW-2:0]   r;
      logic [RW-1:0]   dst;
      logic [3*QW-1:0] num;
      logic [3*QW-1:0] rem;
      logic [3*QW-1:0] quo;
   } dv_type;
   dv_type dv_ff [QW+1];
   logic   dv_v_ff [QW+1];
   logic [RW-1:0] dist_c;
   logic [QW-1:0] num_c [3];
   always_comb begin
      dist_c = rt_ff[RW].root;
      if (DW'(rt_ff[RW].rem) > DW'(rt_ff[RW].root)) dist_c = rt_ff[RW].root + RW'(1);
      if (dist_c == '0) dist_c = RW'(1);
      for (int i = 0; i < 3; i++)
         num_c[i] = (QW'(rt_ff[RW].ad[i*CW +: CW]) << NORM_SHIFT) + QW'(dist_c >> 1);
   end
   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (en) dv_v_ff[0] <= rt_v_ff[RW];
      if (en) begin
         dv_ff[0].inbox  <= rt_ff[RW].inbox;
         dv_ff[0].miss   <= rt_ff[RW].miss;
         dv_ff[0].neg    <= rt_ff[RW].neg;
         dv_ff[0].p      <= rt_ff[RW].p;
         dv_ff[0].r      <= rt_ff[RW].r;
         dv_ff[0].dst    <= dist_c;
         dv_ff[0].num    <= {num_c[2], num_c[1], num_c[0]};
         dv_ff[0].rem    <= '0;
         dv_ff[0].quo    <= '0;
      end
   end

   // divider chain: one quotient bit per cell for all three axes
   for (genvar k = 0; k < QW; k++) begin : g_div
      localparam int B = QW-1-k;
      dv_type nx;
      logic [QW-1:0] rn [3];
      logic [2:0]    qb;
      for (genvar a = 0; a < 3; a++) begin : g_axis
         sbc_cell #(.QW(QW), .RW(RW)) u_cell (
            .rem_cur(dv_ff[k].rem[a*QW +: QW]),
            .num_bit(dv_ff[k].num[a*QW + B]),
            .divisor(dv_ff[k].dst),
            .rem_nxt(rn[a]),
            .q_bit(qb[a])
         );
      end
      always_comb begin
         nx = dv_ff[k];
         for (int i = 0; i < 3; i++) begin
            nx.rem[i*QW +: QW] = rn[i];
            nx.quo[i*QW + B]   = qb[i];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[k+1] <= 1'b0;
         else if (en) dv_v_ff[k+1] <= dv_v_ff[k];
         if (en) dv_ff[k+1] <= nx;
      end
   end

   // finish: saturate, sign, depth, select
   logic [QW-1:0] qs [3];
   logic signed [NORM_WIDTH-1:0] nv [3];
   logic [CW-2:0] dep;
   logic hitc, valc;
   dv_type f;
   always_comb begin
      f = dv_ff[QW];
      for (int i = 0; i < 3; i++) begin
         qs[i] = f.quo[i*QW +: QW];
         if (qs[i] > QW'(NORM_ONE)) qs[i] = QW'(NORM_ONE);
         nv[i] = f.neg[i] ? -NORM_WIDTH'(qs[i]) : NORM_WIDTH'(qs[i]);
      end
      dep  = (RW'(f.r) > f.dst) ? (CW-1)'(RW'(f.r) - f.dst) : '0;
      hitc = f.inbox || !f.miss;
      valc = !f.inbox && !f.miss;
   end
   always_ff @(posedge clock) begin
      if (reset) rsp.valid <= 1'b0;
      else if (en) rsp.valid <= dv_v_ff[QW];
      if (en) begin
         rsp.hit       <= hitc;
         rsp.contact_x <= valc ? f.p[0 +: CW]    : '0;
         rsp.contact_y <= valc ? f.p[CW +: CW]   : '0;
         rsp.contact_z <= valc ? f.p[2*CW +: CW] : '0;
         rsp.normal_x  <= valc ? nv[0] : '0;
         rsp.normal_y  <= valc ? nv[1] : '0;
         rsp.normal_z  <= valc ? nv[2] : '0;
         rsp.depth     <= valc ? dep : '0;
      end
   end

   // a result that is not taken holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.depth))
      else $error("result dropped under stall");
   // a nonzero depth comes only with a hit
   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.depth != '0 |-> rsp.hit)
      else $error("depth on a miss");
   // miss carries zero normal_x and normal_y
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.hit |-> rsp.normal_x == '0 && rsp.normal_y == '0)
      else $error("normal on a miss");
endmodule

### rtl/core/sbc_cell.sv
// One restoring division step for one axis: shift in the next dividend bit,
// take the divisor off where it fits and hand out the quotient bit.
module sbc_cell #(
   parameter int QW = 31,
   parameter int RW = 17
) (
   input  logic [QW-1:0] rem_cur,
   input  logic          num_bit,
   input  logic [RW-1:0] divisor,
   output logic [QW-1:0] rem_nxt,
   output logic          q_bit
);
   logic [QW:0] t;

   // trial subtract
   always_comb begin
      t = {rem_cur, num_bit};
      if (t >= (QW+1)'(divisor)) begin
         rem_nxt = QW'(t - (QW+1)'(divisor));
         q_bit   = 1'b1;
      end else begin
         rem_nxt = t[QW-1:0];
         q_bit   = 1'b0;
      end
   end
endmodule

### tb/sphere_box_collision_tb.sv
module sphere_box_collision_tb;
   import sbc_pkg::*;

   localparam int CW = 16;
   localparam int LATENCY = 80;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic signed [15:0] cz;
      logic [14:0]        rad;
   } query_t;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic [14:0]        depth;
   } contact_t;

   // directed row: query, optional literal answer
   typedef struct packed {
      query_t   q;
      logic     typed;
      contact_t ans;
   } row_t;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   sbc_req_if #(.CW(CW)) req ();
   sbc_rsp_if #(.CW(CW)) rsp ();

   sphere_box_collision #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // box as the block should hold it
   logic signed [15:0] box_lo [3];
   logic signed [15:0] box_hi [3];

   contact_t pending_contacts [$];
   int  errors;
   int  send_idle_pct, recv_idle_pct;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned root_rounded(longint unsigned v);
      longint unsigned r, b, x;
      r = 0; b = 64'd1 << 62; x = v;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (v > r * r + r) r += 1;
      if (r == 0) r = 1;
      return r;
   endfunction

   // sphere against box: closest point, normal and depth
   function automatic contact_t collide(query_t q);
      contact_t o;
      longint c [3];
      longint p [3];
      longint d [3];
      longint unsigned ad [3];
      longint unsigned dsq, dst, qn, r;
      bit inbox;
      o = '0;
      c[0] = longint'(q.cx); c[1] = longint'(q.cy); c[2] = longint'(q.cz);
      r = 64'(q.rad);
      inbox = 1;
      dsq = 0;
      for (int i = 0; i < 3; i++)
         if (c[i] < box_lo[i] || c[i] > box_hi[i]) inbox = 0;
      if (inbox) begin
         o.hit = 1'b1;
         return o;
      end
      for (int i = 0; i < 3; i++) begin
         if (box_lo[i] > c[i]) p[i] = box_lo[i];
         else if (box_hi[i] < c[i]) p[i] = box_hi[i];
         else p[i] = c[i];
         d[i] = c[i] - p[i];
         ad[i] = d[i] < 0 ? -d[i] : d[i];
         if (ad[i] > r) return o;
      end
      for (int i = 0; i < 3; i++) dsq += ad[i] * ad[i];
      if (dsq > r * r) return o;
      dst = root_rounded(dsq);
      o.hit = 1'b1;
      o.px = 16'(p[0]); o.py = 16'(p[1]); o.pz = 16'(p[2]);
      for (int i = 0; i < 3; i++) begin
         logic signed [15:0] n;
         qn = (ad[i] * 16384 + dst / 2) / dst;
         if (qn > 16384) qn = 16384;
         n = d[i] < 0 ? -$signed(16'(qn)) : $signed(16'(qn));
         if (i == 0) o.nx = n; else if (i == 1) o.ny = n; else o.nz = n;
      end
      o.depth = r > dst ? 15'(r - dst) : '0;
      return o;
   endfunction

   task automatic write_box(reg_index_type idx, logic signed [15:0] v);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx) << 2; csr_pwdata <= 32'($signed(v));
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx < REG_MAX_X) box_lo[idx] = v; else box_hi[idx - REG_MAX_X] = v;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_box(logic signed [15:0] lx, ly, lz, hx, hy, hz);
      write_box(REG_MIN_X, lx); write_box(REG_MIN_Y, ly); write_box(REG_MIN_Z, lz);
      write_box(REG_MAX_X, hx); write_box(REG_MAX_Y, hy); write_box(REG_MAX_Z, hz);
   endtask

   // wait for the pipeline to empty
   task automatic drain();
      while (pending_contacts.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // one request; driven at falling edge, accepted at rising edge
   task automatic send_query(query_t q, bit typed, contact_t ans);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.center_x <= q.cx; req.center_y <= q.cy; req.center_z <= q.cz;
      req.radius <= q.rad;
      do @(posedge clock); while (!req.ready);
      pending_contacts.push_back(typed ? ans : collide(q));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   function automatic query_t random_query(int mode);
      query_t q;
      q.cx = 16'($urandom); q.cy = 16'($urandom); q.cz = 16'($urandom);
      q.rad = 15'($urandom);
      if (mode != 0) begin
         // near the box, so that most queries probe contact
         q.cx = 16'(box_lo[0] + $signed(16'($urandom_range(1200))) - 300);
         q.cy = 16'(box_lo[1] + $signed(16'($urandom_range(1200))) - 300);
         q.cz = 16'(box_lo[2] + $signed(16'($urandom_range(1200))) - 300);
         q.rad = 15'($urandom_range(600));
      end
      return q;
   endfunction

   // result checking
   always @(posedge clock) begin
      contact_t got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.hit, rsp.contact_x, rsp.contact_y, rsp.contact_z,
                rsp.normal_x, rsp.normal_y, rsp.normal_z, rsp.depth};
         if (pending_contacts.size() == 0) begin
            $error("unexpected result");
            errors++;
         end else begin
            want = pending_contacts.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit exp %0d got %0d", want.hit, got.hit); errors++;
            end
            if (got.px !== want.px) begin
               $error("contact_x exp %0d got %0d", want.px, got.px); errors++;
            end
            if (got.py !== want.py) begin
               $error("contact_y exp %0d got %0d", want.py, got.py); errors++;
            end
            if (got.pz !== want.pz) begin
               $error("contact_z exp %0d got %0d", want.pz, got.pz); errors++;
            end
            if (got.nx !== want.nx) begin
               $error("normal_x exp %0d got %0d", want.nx, got.nx); errors++;
            end
            if (got.ny !== want.ny) begin
               $error("normal_y exp %0d got %0d", want.ny, got.ny); errors++;
            end
            if (got.nz !== want.nz) begin
               $error("normal_z exp %0d got %0d", want.nz, got.nz); errors++;
            end
            if (got.depth !== want.depth) begin
               $error("depth exp %0d got %0d", want.depth, got.depth); errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock)
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[sphere_box_collision] ERROR");
         $finish;
      end
   end

   initial begin
      row_t rows [$];
      row_t rw;
      query_t q;
      contact_t z;
      int phase_items;
      errors = 0; cycles = 0;
      send_idle_pct = 0; recv_idle_pct = 0;
      z = '0;
      reset = 1'b1;
      req.valid = 1'b0; req.center_x = '0; req.center_y = '0; req.center_z = '0;
      req.radius = '0; rsp.ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = '0; box_hi[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // after reset the box is the origin point
      rw = '0; rw.typed = 1; rw.ans = '0; rw.ans.hit = 1; rows.push_back(rw);
      rw = '0; rw.q = {16'sh7fff, 16'sh0, 16'sh0, 15'h7fff}; rw.typed = 1;
      rw.ans = '0; rw.ans.hit = 1; rw.ans.nx = 16'sd16384; rw.ans.depth = '0;
      rows.push_back(rw);
      rw = '0; rw.q = {16'sh8000, 16'sh0, 16'sh0, 15'h0}; rw.typed = 1; rw.ans = z;
      rows.push_back(rw);
      rw = '0; rw.q = {16'sh0, 16'sh0, 16'shff00, 15'h200}; rows.push_back(rw);
      foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].ans);
      end_burst();
      drain();

      // normal box with surface, edge, corner, early miss cases
      set_box(-16'sd256, -16'sd256, -16'sd256, 16'sd256, 16'sd256, 16'sd256);
      rows.delete();
      rw = '0; rw.q = {16'sd256, 16'sd0, -16'sd256, 15'd0}; rw.typed = 1;
      rw.ans = '0; rw.ans.hit = 1; rows.push_back(rw);
      rw = '0; rw.q = {16'sd356, 16'sd0, 16'sd0, 15'd50}; rw.typed = 1; rw.ans = z;
      rows.push_back(rw);
      rw = '0; rw.q = {16'sd356, 16'sd356, 16'sd0, 15'd200}; rows.push_back(rw);
      rw = '0; rw.q = {16'sd356, 16'sd356, 16'sd356, 15'd174}; rows.push_back(rw);
      rw = '0; rw.q = {16'sd356, 16'sd356, 16'sd356, 15'd173}; rows.push_back(rw);
      rw = '0; rw.q = {-16'sd300, 16'sd0, 16'sd0, 15'd44}; rows.push_back(rw);
      rw = '0; rw.q = {16'sd0, 16'sd0, 16'sd400, 15'd143}; rows.push_back(rw);
      rw = '0; rw.q = {16'sd0, -16'sd400, 16'sd0, 15'd144}; rows.push_back(rw);
      rw = '0; rw.q = {16'sh7fff, 16'sh7fff, 16'sh7fff, 15'h7fff}; rows.push_back(rw);
      rw = '0; rw.q = {16'sh8000, 16'sh8000, 16'sh8000, 15'h7fff}; rows.push_back(rw);
      foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].ans);
      end_burst();
      drain();

      // inverted box: nothing inside
      set_box(16'sd100, 16'sd100, 16'sd100, -16'sd100, -16'sd100, -16'sd100);
      send_query({16'sd0, 16'sd0, 16'sd0, 15'd300}, 0, z);
      send_query({16'sd150, -16'sd150, 16'sd0, 15'd300}, 0, z);
      end_burst();
      drain();

      // random phases: receiver idles more, then sender idles more, then none
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 3)
            0: begin send_idle_pct = 32; recv_idle_pct = 60; end
            1: begin send_idle_pct = 60; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (ph)
            0: set_box(-16'sd512, -16'sd300, -16'sd100, 16'sd512, 16'sd300, 16'sd100);
            1: set_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
            2: set_box(16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
            3: set_box(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
            4: set_box(-16'sd20, -16'sd20, -16'sd20, 16'sd20, 16'sd20, 16'sd20);
            default: set_box(16'sd1000, -16'sd2000, 16'sd0, 16'sd1400, -16'sd1900, 16'sd0);
         endcase
         phase_items = 170;
         for (int k = 0; k < phase_items; k++) begin
            q = random_query($urandom_range(99) < 75);
            send_query(q, 0, z);
            if (k == phase_items / 2 && ph == 0) begin
               // hold off until everything in flight has come out
               end_burst();
               while (pending_contacts.size() != 0) @(posedge clock);
            end
         end
         end_burst();
         drain();
      end

      send_idle_pct = 0; recv_idle_pct = 0;
      if (errors == 0) begin
         $display("[sphere_box_collision] OK");
      end else begin
         $display("[sphere_box_collision] ERROR");
      end
      $finish;
   end
endmodule

### filelist.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_if.sv
rtl/core/sbc_cell.sv
rtl/core/sphere_box_collision.sv
tb/sphere_box_collision_tb.sv
